@@ sv/fct_pkg.sv @@
// Shared constants and types for the cluster table engine.
// Used by the table RAM, the sector unit and the top level; depends on nothing.
package fct_pkg;

    localparam int CLUSTERS = 4096;
    localparam int CL_W     = $clog2(CLUSTERS);
    localparam int LIM_W    = CL_W + 1;
    localparam int TOT_W    = 13;
    localparam int CMP_W    = (TOT_W > LIM_W) ? TOT_W : LIM_W;
    localparam int ENT_W    = 28;
    localparam int SPC_W    = 8;
    localparam int SEC_W    = 32;
    localparam int PROD_W   = CL_W + SPC_W;

    localparam logic [ENT_W-1:0] ENTRY_MASK = 28'h0FFF_FFFF;
    localparam logic [ENT_W-1:0] EOC_MIN    = 28'h0FFF_FFF8;
    localparam logic [ENT_W-1:0] EOC_MARK   = 28'h0FFF_FFFF;
    localparam logic [ENT_W-1:0] FIRST_CLUSTER = 28'd2;

    // Operation codes carried in the input kind field.
    localparam logic [2:0] KIND_READ  = 3'd0;
    localparam logic [2:0] KIND_WRITE = 3'd1;
    localparam logic [2:0] KIND_ALLOC = 3'd2;
    localparam logic [2:0] KIND_FREE  = 3'd3;
    localparam logic [2:0] KIND_SET   = 3'd4;

    // Result status codes.
    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_RANGE = 2'd1;
    localparam logic [1:0] ST_FULL  = 2'd2;
    localparam logic [1:0] ST_LOOP  = 2'd3;

    // Configuration register indexes.
    localparam logic [1:0] CFG_SPC   = 2'd0;
    localparam logic [1:0] CFG_FDS   = 2'd1;
    localparam logic [1:0] CFG_TOTAL = 2'd2;

    // One request to the table RAM: one write port, one read port.
    typedef struct packed {
        logic             we;
        logic [CL_W-1:0]  waddr;
        logic [ENT_W-1:0] wdata;
        logic             re;
        logic [CL_W-1:0]  raddr;
    } ram_req_t;

endpackage

@@ sv/fct_ram.sv @@
// Allocation table memory: one write port and one registered read port.
// Depends on fct_pkg for depth, entry width and the request struct.
module fct_ram (
    input  logic                         aclk,
    input  fct_pkg::ram_req_t            req,
    output logic [fct_pkg::ENT_W-1:0]    rd_data
);

    logic [fct_pkg::ENT_W-1:0] mem [fct_pkg::CLUSTERS];
    logic [fct_pkg::ENT_W-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (req.we) begin
            mem[req.waddr] <= req.wdata;
        end
        if (req.re) begin
            rd_data_reg <= mem[req.raddr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

@@ sv/fct_sector.sv @@
// Data sector unit: (index * sectors per cluster) + first data sector in two stages.
// Depends on fct_pkg for widths.
module fct_sector (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          start,
    input  logic [fct_pkg::CL_W-1:0]      idx,
    input  logic [fct_pkg::SPC_W-1:0]     spc,
    input  logic [fct_pkg::SEC_W-1:0]     fds,
    output logic                          done,
    output logic [fct_pkg::SEC_W-1:0]     sector
);

    logic [fct_pkg::PROD_W-1:0] prod_reg;
    logic [fct_pkg::SEC_W-1:0]  sum_reg;
    logic                       v1_reg;
    logic                       done_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg   <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            v1_reg   <= start;
            done_reg <= v1_reg;
        end
        // The product register splits the multiplier from the wide add.
        prod_reg <= fct_pkg::PROD_W'(idx) * fct_pkg::PROD_W'(spc);
        sum_reg  <= fct_pkg::SEC_W'(prod_reg) + fds;
    end

    assign done   = done_reg;
    assign sector = sum_reg;

endmodule

@@ sv/fat32_cluster_table_engine.sv @@
// Top level of the cluster table engine: configuration, sequencer and result register.
// Depends on fct_pkg, fct_ram and fct_sector.
//
// The engine keeps a FAT32-style allocation table of 4096 entries of 28 bits in an
// internal RAM, plus a free-cluster count, and handles one request beat at a time.
// After reset a clearing pass writes every entry to zero, one entry per cycle, and
// s_tready stays low until it ends; configuration writes are taken meanwhile.
// Every operation then runs through one sequencer that shares the RAM's single
// read port and a two-stage sector multiply-add unit. Allocate scans the table one
// entry per cycle from cluster two, up to the usable limit. Free walks the chain
// twice, first to check it and then to clear it. A finished result waits in the
// output register, and the next request beat is taken while it waits.
module fat32_cluster_table_engine (
    input  logic         aclk,
    input  logic         aresetn,
    // Configuration write port.
    input  logic         cfg_we,
    input  logic [1:0]   cfg_index,
    input  logic [31:0]  cfg_wdata,
    // Request channel.
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [55:0]  s_tdata,   // cluster [27:0], value [55:28]
    input  logic [2:0]   s_tuser,   // kind [2:0]
    // Result channel.
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [87:0]  m_tdata,   // next_cluster [27:0], data_sector [59:28],
                                    // free_count [87:60]
    output logic [2:0]   m_tuser    // end_of_chain [0], status [2:1]
);

    localparam int CL_W  = fct_pkg::CL_W;
    localparam int LIM_W = fct_pkg::LIM_W;
    localparam int CMP_W = fct_pkg::CMP_W;
    localparam int ENT_W = fct_pkg::ENT_W;

    localparam logic [3:0] S_CLR    = 4'd0;
    localparam logic [3:0] S_IDLE   = 4'd1;
    localparam logic [3:0] S_DISP   = 4'd2;
    localparam logic [3:0] S_RD_DAT = 4'd3;
    localparam logic [3:0] S_SCAN   = 4'd4;
    localparam logic [3:0] S_LINK   = 4'd5;
    localparam logic [3:0] S_MARK   = 4'd6;
    localparam logic [3:0] S_W1_RD  = 4'd7;
    localparam logic [3:0] S_W1_CK  = 4'd8;
    localparam logic [3:0] S_W2_RD  = 4'd9;
    localparam logic [3:0] S_W2_WR  = 4'd10;
    localparam logic [3:0] S_SEC_GO = 4'd11;
    localparam logic [3:0] S_SEC_WT = 4'd12;
    localparam logic [3:0] S_FIN    = 4'd13;

    // Configuration registers.
    logic [fct_pkg::SPC_W-1:0] spc_reg;
    logic [fct_pkg::SEC_W-1:0] fds_reg;
    logic [fct_pkg::TOT_W-1:0] tot_reg;

    // Sequencer state and working registers.
    logic [3:0]       state_reg, state_next;
    logic [CL_W-1:0]  clr_reg, clr_next;
    logic [2:0]       kind_reg, kind_next;
    logic [ENT_W-1:0] c_reg, c_next;
    logic [ENT_W-1:0] v_reg, v_next;
    logic [ENT_W-1:0] free_reg, free_next;
    logic [LIM_W-1:0] scan_reg, scan_next;
    logic             pend_reg, pend_next;
    logic [CL_W-1:0]  pend_addr_reg, pend_addr_next;
    logic [CL_W-1:0]  cur_reg, cur_next;
    logic [LIM_W-1:0] n_reg, n_next;
    logic [CL_W-1:0]  tgt_reg, tgt_next;
    logic [ENT_W-1:0] res_next_reg, res_next_next;
    logic             res_eoc_reg, res_eoc_next;
    logic [1:0]       res_st_reg, res_st_next;
    logic             sec_ok_reg, sec_ok_next;

    // Output register.
    logic             m_valid_reg;
    logic [87:0]      m_data_reg;
    logic [2:0]       m_user_reg;

    fct_pkg::ram_req_t         ram_req;
    logic [ENT_W-1:0]          rd_data;
    logic                      sec_start;
    logic                      sec_done;
    logic [fct_pkg::SEC_W-1:0] sec_value;

    logic [CMP_W-1:0] tot_ext;
    logic [LIM_W-1:0] lim;
    logic [ENT_W-1:0] lim_ext;
    logic             c_in_range;
    logic             rd_in_range;
    logic             s_fire;
    logic             out_free;

    // Usable limit is the smaller of total_clusters and the table depth.
    assign tot_ext = CMP_W'(tot_reg);
    assign lim     = (tot_ext > CMP_W'(fct_pkg::CLUSTERS)) ? LIM_W'(fct_pkg::CLUSTERS)
                                                           : LIM_W'(tot_ext);
    assign lim_ext = ENT_W'(lim);

    assign c_in_range  = (c_reg >= fct_pkg::FIRST_CLUSTER) && (c_reg < lim_ext);
    assign rd_in_range = (rd_data >= fct_pkg::FIRST_CLUSTER) && (rd_data < lim_ext);

    assign s_tready = (state_reg == S_IDLE);
    assign s_fire   = s_tvalid && s_tready;
    assign out_free = !m_valid_reg || m_tready;

    fct_ram u_ram (
        .aclk    (aclk),
        .req     (ram_req),
        .rd_data (rd_data)
    );

    fct_sector u_sector (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (sec_start),
        .idx     (CL_W'(tgt_reg - CL_W'(fct_pkg::FIRST_CLUSTER))),
        .spc     (spc_reg),
        .fds     (fds_reg),
        .done    (sec_done),
        .sector  (sec_value)
    );

    always_comb begin
        state_next     = state_reg;
        clr_next       = clr_reg;
        kind_next      = kind_reg;
        c_next         = c_reg;
        v_next         = v_reg;
        free_next      = free_reg;
        scan_next      = scan_reg;
        pend_next      = pend_reg;
        pend_addr_next = pend_addr_reg;
        cur_next       = cur_reg;
        n_next         = n_reg;
        tgt_next       = tgt_reg;
        res_next_next  = res_next_reg;
        res_eoc_next   = res_eoc_reg;
        res_st_next    = res_st_reg;
        sec_ok_next    = sec_ok_reg;
        sec_start      = 1'b0;
        ram_req        = '0;

        case (state_reg)
            S_CLR: begin
                // Clearing pass: every entry starts out free.
                ram_req.we    = 1'b1;
                ram_req.waddr = clr_reg;
                ram_req.wdata = '0;
                clr_next      = clr_reg + CL_W'(1);
                if (clr_reg == {CL_W{1'b1}}) begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE: begin
                if (s_fire) begin
                    kind_next     = s_tuser;
                    c_next        = s_tdata[27:0];
                    v_next        = s_tdata[55:28];
                    res_next_next = '0;
                    res_eoc_next  = 1'b0;
                    res_st_next   = fct_pkg::ST_OK;
                    sec_ok_next   = 1'b0;
                    state_next    = S_DISP;
                end
            end
            S_DISP: begin
                case (kind_reg)
                    fct_pkg::KIND_READ: begin
                        if (!c_in_range) begin
                            res_st_next = fct_pkg::ST_RANGE;
                            state_next  = S_FIN;
                        end else begin
                            ram_req.re    = 1'b1;
                            ram_req.raddr = c_reg[CL_W-1:0];
                            state_next    = S_RD_DAT;
                        end
                    end
                    fct_pkg::KIND_WRITE: begin
                        if (!c_in_range) begin
                            res_st_next = fct_pkg::ST_RANGE;
                            state_next  = S_FIN;
                        end else begin
                            ram_req.we    = 1'b1;
                            ram_req.waddr = c_reg[CL_W-1:0];
                            ram_req.wdata = v_reg;
                            tgt_next      = c_reg[CL_W-1:0];
                            state_next    = S_SEC_GO;
                        end
                    end
                    fct_pkg::KIND_ALLOC: begin
                        if ((c_reg != '0) && !c_in_range) begin
                            res_st_next = fct_pkg::ST_RANGE;
                            state_next  = S_FIN;
                        end else if (free_reg == '0) begin
                            res_st_next = fct_pkg::ST_FULL;
                            state_next  = S_FIN;
                        end else begin
                            scan_next  = LIM_W'(fct_pkg::FIRST_CLUSTER);
                            pend_next  = 1'b0;
                            state_next = S_SCAN;
                        end
                    end
                    fct_pkg::KIND_FREE: begin
                        if (!c_in_range) begin
                            res_st_next = fct_pkg::ST_RANGE;
                            state_next  = S_FIN;
                        end else begin
                            cur_next   = c_reg[CL_W-1:0];
                            n_next     = LIM_W'(1);
                            state_next = S_W1_RD;
                        end
                    end
                    fct_pkg::KIND_SET: begin
                        free_next  = v_reg;
                        state_next = S_FIN;
                    end
                    default: begin
                        state_next = S_FIN;
                    end
                endcase
            end
            S_RD_DAT: begin
                res_next_next = rd_data;
                res_eoc_next  = (rd_data >= fct_pkg::EOC_MIN);
                tgt_next      = c_reg[CL_W-1:0];
                state_next    = S_SEC_GO;
            end
            S_SCAN: begin
                // One read issued per cycle while below the limit; the data of the previous read is checked.
                if (scan_reg < lim) begin
                    ram_req.re    = 1'b1;
                    ram_req.raddr = scan_reg[CL_W-1:0];
                    scan_next     = scan_reg + LIM_W'(1);
                end
                pend_next      = (scan_reg < lim);
                pend_addr_next = scan_reg[CL_W-1:0];
                if (pend_reg && (rd_data == '0)) begin
                    tgt_next   = pend_addr_reg;
                    state_next = S_LINK;
                end else if (!pend_reg && (scan_reg >= lim)) begin
                    res_st_next = fct_pkg::ST_FULL;
                    state_next  = S_FIN;
                end
            end
            S_LINK: begin
                if (c_reg != '0) begin
                    ram_req.we    = 1'b1;
                    ram_req.waddr = c_reg[CL_W-1:0];
                    ram_req.wdata = ENT_W'(tgt_reg);
                end
                state_next = S_MARK;
            end
            S_MARK: begin
                // Written after the link, so a predecessor equal to the new
                // cluster ends up marked as end of chain.
                ram_req.we    = 1'b1;
                ram_req.waddr = tgt_reg;
                ram_req.wdata = fct_pkg::EOC_MARK;
                free_next     = free_reg - ENT_W'(1);
                res_next_next = ENT_W'(tgt_reg);
                state_next    = S_SEC_GO;
            end
            S_W1_RD: begin
                ram_req.re    = 1'b1;
                ram_req.raddr = cur_reg;
                state_next    = S_W1_CK;
            end
            S_W1_CK: begin
                if (rd_data >= fct_pkg::EOC_MIN) begin
                    cur_next   = c_reg[CL_W-1:0];
                    state_next = S_W2_RD;
                end else if (!rd_in_range) begin
                    res_st_next = fct_pkg::ST_RANGE;
                    state_next  = S_FIN;
                end else if (n_reg >= (lim - LIM_W'(2))) begin
                    res_st_next = fct_pkg::ST_LOOP;
                    state_next  = S_FIN;
                end else begin
                    cur_next   = rd_data[CL_W-1:0];
                    n_next     = n_reg + LIM_W'(1);
                    state_next = S_W1_RD;
                end
            end
            S_W2_RD: begin
                ram_req.re    = 1'b1;
                ram_req.raddr = cur_reg;
                state_next    = S_W2_WR;
            end
            S_W2_WR: begin
                ram_req.we    = 1'b1;
                ram_req.waddr = cur_reg;
                ram_req.wdata = '0;
                if (free_reg != fct_pkg::ENTRY_MASK) begin
                    free_next = free_reg + ENT_W'(1);
                end
                if (rd_in_range) begin
                    cur_next = rd_data[CL_W-1:0];
                end
                n_next = n_reg - LIM_W'(1);
                if (n_reg == LIM_W'(1)) begin
                    tgt_next   = c_reg[CL_W-1:0];
                    state_next = S_SEC_GO;
                end else begin
                    state_next = S_W2_RD;
                end
            end
            S_SEC_GO: begin
                sec_start   = 1'b1;
                sec_ok_next = 1'b1;
                state_next  = S_SEC_WT;
            end
            S_SEC_WT: begin
                if (sec_done) begin
                    state_next = S_FIN;
                end
            end
            S_FIN: begin
                if (out_free) begin
                    state_next = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_CLR;
            clr_reg     <= '0;
            free_reg    <= '0;
            pend_reg    <= 1'b0;
            m_valid_reg <= 1'b0;
            spc_reg     <= fct_pkg::SPC_W'(1);
            fds_reg     <= '0;
            tot_reg     <= fct_pkg::TOT_W'(4096);
        end else begin
            state_reg <= state_next;
            clr_reg   <= clr_next;
            free_reg  <= free_next;
            pend_reg  <= pend_next;
            if (cfg_we) begin
                case (cfg_index)
                    fct_pkg::CFG_SPC:   spc_reg <= cfg_wdata[fct_pkg::SPC_W-1:0];
                    fct_pkg::CFG_FDS:   fds_reg <= cfg_wdata;
                    fct_pkg::CFG_TOTAL: tot_reg <= cfg_wdata[fct_pkg::TOT_W-1:0];
                    default: begin
                    end
                endcase
            end
            if ((state_reg == S_FIN) && out_free) begin
                m_valid_reg <= 1'b1;
            end else if (m_tready) begin
                m_valid_reg <= 1'b0;
            end
        end
        kind_reg      <= kind_next;
        c_reg         <= c_next;
        v_reg         <= v_next;
        scan_reg      <= scan_next;
        pend_addr_reg <= pend_addr_next;
        cur_reg       <= cur_next;
        n_reg         <= n_next;
        tgt_reg       <= tgt_next;
        res_next_reg  <= res_next_next;
        res_eoc_reg   <= res_eoc_next;
        res_st_reg    <= res_st_next;
        sec_ok_reg    <= sec_ok_next;
        if ((state_reg == S_FIN) && out_free) begin
            m_data_reg[27:0]  <= res_next_reg;
            m_data_reg[59:28] <= (sec_ok_reg && (res_st_reg == fct_pkg::ST_OK))
                                 ? sec_value : '0;
            m_data_reg[87:60] <= free_reg;
            m_user_reg        <= {res_st_reg, res_eoc_reg};
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;
    assign m_tuser  = m_user_reg;

endmodule

@@ test/tb_fat32_cluster_table_engine.sv @@
// Self-checking testbench for fat32_cluster_table_engine: directed table, then random phases.
// Depends on fct_pkg for operation, status and register codes; drives the top level only.
module tb_fat32_cluster_table_engine;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int ENT_W = fct_pkg::ENT_W;
    localparam int SEC_W = fct_pkg::SEC_W;
    localparam int SPC_W = fct_pkg::SPC_W;
    localparam int TOT_W = fct_pkg::TOT_W;

    // One result beat, unpacked into its fields.
    typedef struct packed {
        logic [ENT_W-1:0] next_cluster;
        logic             end_of_chain;
        logic [SEC_W-1:0] data_sector;
        logic [ENT_W-1:0] free_count;
        logic [1:0]       status;
    } cluster_result_t;

    // One row of the directed table. Rows with typed set carry their own expected
    // result; all other rows are checked against the table predictor.
    typedef struct packed {
        logic [2:0]       kind;
        logic [ENT_W-1:0] cluster;
        logic [ENT_W-1:0] value;
        logic             typed;
        cluster_result_t  want;
    } stim_row_t;

    logic         aclk      = 1'b0;
    logic         aresetn   = 1'b0;
    logic         cfg_we    = 1'b0;
    logic [1:0]   cfg_index = fct_pkg::CFG_SPC;
    logic [31:0]  cfg_wdata = '0;
    logic         s_tvalid  = 1'b0;
    logic         s_tready;
    logic [55:0]  s_tdata   = '0;   // cluster [27:0], value [55:28]
    logic [2:0]   s_tuser   = fct_pkg::KIND_READ;   // kind [2:0]
    logic         m_tvalid;
    logic         m_tready  = 1'b0;
    logic [87:0]  m_tdata;          // next_cluster [27:0], data_sector [59:28],
                                    // free_count [87:60]
    logic [2:0]   m_tuser;          // end_of_chain [0], status [2:1]

    fat32_cluster_table_engine i_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // Private copy of the allocation table, the free count and the registers.
    // The copy starts in the reset state: every entry free, zero free count, one
    // sector per cluster, data region at sector zero, the full table in use.
    logic [ENT_W-1:0] fat_copy [fct_pkg::CLUSTERS];
    logic [ENT_W-1:0] free_copy  = '0;
    logic [SPC_W-1:0] spc_copy   = 8'd1;
    logic [SEC_W-1:0] fds_copy   = '0;
    logic [TOT_W-1:0] total_copy = 13'd4096;

    // Results still owed by the engine, oldest first.
    cluster_result_t pending_results [$];
    cluster_result_t oldest_result;

    // Directed stimulus, walked in order after reset.
    stim_row_t directed_rows [$];

    int send_idle_pct  = 0;
    int recv_stall_pct = 0;
    int mismatch_count = 0;

    // The table size in force is the smaller of the register and the RAM depth.
    function automatic int usable_limit();
        return (int'(total_copy) > fct_pkg::CLUSTERS) ? fct_pkg::CLUSTERS : int'(total_copy);
    endfunction

    function automatic logic valid_cluster(input logic [ENT_W-1:0] c);
        return (c >= fct_pkg::FIRST_CLUSTER) && (int'(c) < usable_limit());
    endfunction

    // First sector of a cluster's data, wrapping at 32 bits.
    function automatic logic [SEC_W-1:0] sector_for(input logic [ENT_W-1:0] c);
        return (32'(c) - 32'd2) * 32'(spc_copy) + fds_copy;
    endfunction

    // Applies one request to the table copy and returns the result it produces.
    function automatic cluster_result_t table_step(input logic [2:0] kind,
                                                   input logic [ENT_W-1:0] c,
                                                   input logic [ENT_W-1:0] v);
        cluster_result_t r;
        logic [1:0]      st;
        int              lim;
        int              found;
        int              cur;
        int              link;
        int              n;
        int              k;
        logic            walking;
        r   = '0;
        st  = fct_pkg::ST_OK;
        lim = usable_limit();
        case (kind)
            fct_pkg::KIND_READ, fct_pkg::KIND_WRITE: begin
                if (!valid_cluster(c)) begin
                    st = fct_pkg::ST_RANGE;
                end else begin
                    if (kind == fct_pkg::KIND_READ) begin
                        r.next_cluster = fat_copy[c];
                        r.end_of_chain = (fat_copy[c] >= fct_pkg::EOC_MIN);
                    end else begin
                        fat_copy[c] = v;
                    end
                    r.data_sector = sector_for(c);
                end
            end
            fct_pkg::KIND_ALLOC: begin
                if (c != '0 && !valid_cluster(c)) begin
                    st = fct_pkg::ST_RANGE;
                end else if (free_copy == '0) begin
                    st = fct_pkg::ST_FULL;
                end else begin
                    found = 0;
                    for (k = 2; k < lim; k++) begin
                        if (fat_copy[k] == '0) begin
                            found = k;
                            break;
                        end
                    end
                    if (found == 0) begin
                        // The count may claim free clusters that the table lacks.
                        st = fct_pkg::ST_FULL;
                    end else begin
                        // Link first, then mark: a predecessor equal to the found
                        // cluster ends up as an end-of-chain entry.
                        if (c != '0)
                            fat_copy[c] = ENT_W'(found);
                        fat_copy[found] = fct_pkg::EOC_MARK;
                        free_copy       = free_copy - 1'b1;
                        r.next_cluster  = ENT_W'(found);
                        r.data_sector   = sector_for(ENT_W'(found));
                    end
                end
            end
            fct_pkg::KIND_FREE: begin
                if (!valid_cluster(c)) begin
                    st = fct_pkg::ST_RANGE;
                end else begin
                    // Check the whole chain before touching anything.
                    cur     = int'(c);
                    n       = 1;
                    walking = 1'b1;
                    while (walking) begin
                        link = int'(fat_copy[cur]);
                        if (link >= int'(fct_pkg::EOC_MIN)) begin
                            walking = 1'b0;
                        end else if (!valid_cluster(ENT_W'(link))) begin
                            st      = fct_pkg::ST_RANGE;
                            walking = 1'b0;
                        end else if (n >= lim - 2) begin
                            st      = fct_pkg::ST_LOOP;
                            walking = 1'b0;
                        end else begin
                            cur = link;
                            n++;
                        end
                    end
                    if (st == fct_pkg::ST_OK) begin
                        cur = int'(c);
                        for (k = 0; k < n; k++) begin
                            link          = int'(fat_copy[cur]);
                            fat_copy[cur] = '0;
                            if (free_copy < fct_pkg::ENTRY_MASK)
                                free_copy = free_copy + 1'b1;
                            if (valid_cluster(ENT_W'(link)))
                                cur = link;
                        end
                        r.data_sector = sector_for(c);
                    end
                end
            end
            fct_pkg::KIND_SET: begin
                free_copy = v;
            end
            default: begin
            end
        endcase
        r.free_count = free_copy;
        r.status     = st;
        return r;
    endfunction

    function automatic cluster_result_t mk_result(input logic [ENT_W-1:0] next_cluster,
                                                  input logic end_of_chain,
                                                  input logic [SEC_W-1:0] data_sector,
                                                  input logic [ENT_W-1:0] free_count,
                                                  input logic [1:0] status);
        cluster_result_t r;
        r.next_cluster = next_cluster;
        r.end_of_chain = end_of_chain;
        r.data_sector  = data_sector;
        r.free_count   = free_count;
        r.status       = status;
        return r;
    endfunction

    function automatic stim_row_t mk_row(input logic [2:0] kind,
                                         input logic [ENT_W-1:0] cluster,
                                         input logic [ENT_W-1:0] value,
                                         input logic typed,
                                         input cluster_result_t want);
        stim_row_t row;
        row.kind    = kind;
        row.cluster = cluster;
        row.value   = value;
        row.typed   = typed;
        row.want    = want;
        return row;
    endfunction

    // Appends one row to the directed table.
    function automatic void add_row(input logic [2:0] kind,
                                    input logic [ENT_W-1:0] cluster,
                                    input logic [ENT_W-1:0] value,
                                    input logic typed,
                                    input cluster_result_t want);
        directed_rows = {directed_rows, mk_row(kind, cluster, value, typed, want)};
    endfunction

    // Writes all three registers on consecutive edges. Called only while the
    // engine owes no result, right after a rising edge.
    task automatic set_config(input logic [SPC_W-1:0] spc,
                              input logic [SEC_W-1:0] fds,
                              input logic [TOT_W-1:0] total);
        cfg_we    <= 1'b1;
        cfg_index <= fct_pkg::CFG_SPC;
        cfg_wdata <= 32'(spc);
        @(posedge aclk);
        cfg_index <= fct_pkg::CFG_FDS;
        cfg_wdata <= fds;
        @(posedge aclk);
        cfg_index <= fct_pkg::CFG_TOTAL;
        cfg_wdata <= 32'(total);
        @(posedge aclk);
        cfg_we     <= 1'b0;
        spc_copy   = spc;
        fds_copy   = fds;
        total_copy = total;
    endtask

    // Offers one request beat, after a random gap, and records what it must
    // produce once the beat is taken. The valid stays high after acceptance so
    // that back-to-back beats never lower and raise it in one step.
    task automatic send_beat(input logic [2:0] kind,
                             input logic [ENT_W-1:0] cluster,
                             input logic [ENT_W-1:0] value,
                             input logic typed,
                             input cluster_result_t want);
        cluster_result_t predicted;
        while ($urandom_range(99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {value, cluster};
        s_tuser  <= kind;
        do
            @(posedge aclk);
        while (!s_tready);
        predicted = table_step(kind, cluster, value);
        if (typed)
            predicted = want;
        pending_results = {pending_results, predicted};
    endtask

    // Stops offering beats and waits until every owed result has come back.
    task automatic wait_drained();
        s_tvalid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge aclk);
    endtask

    task automatic check_field(input string what, input logic [31:0] want,
                               input logic [31:0] got);
        if (want !== got) begin
            $display("%0t ns: %s mismatch: expected 0x%0h, actual 0x%0h",
                     $time, what, want, got);
            mismatch_count++;
        end
    endtask

    // Result side: every accepted beat is compared with the oldest expectation,
    // then the ready is redrawn for the next edge. Sampling right after the edge
    // sees the values that were present at the edge.
    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            if (pending_results.size() == 0) begin
                $display("%0t ns: result beat with nothing expected, tdata 0x%0h tuser 0x%0h",
                         $time, m_tdata, m_tuser);
                mismatch_count++;
            end else begin
                oldest_result = pending_results.pop_front();
                check_field("next_cluster", 32'(oldest_result.next_cluster), 32'(m_tdata[27:0]));
                check_field("end_of_chain", 32'(oldest_result.end_of_chain), 32'(m_tuser[0]));
                check_field("data_sector", oldest_result.data_sector, m_tdata[59:28]);
                check_field("free_count", 32'(oldest_result.free_count), 32'(m_tdata[87:60]));
                check_field("status", 32'(oldest_result.status), 32'(m_tuser[2:1]));
            end
        end
        m_tready <= ($urandom_range(99) >= recv_stall_pct);
    end

    initial begin
        int          phase;
        int          item_count;
        int          i;
        int          lim;
        int          pick;
        int          sel;
        logic        big;
        logic [2:0]  kind;
        logic [27:0] cluster;
        logic [27:0] value;

        foreach (fat_copy[k])
            fat_copy[k] = '0;

        // Fresh after reset: empty table, zero count, sector = cluster - 2.
        add_row(fct_pkg::KIND_READ, 28'd2, '0, 1'b1,
                mk_result('0, 1'b0, '0, '0, fct_pkg::ST_OK));
        add_row(fct_pkg::KIND_READ, 28'd0, fct_pkg::ENTRY_MASK, 1'b1,
                mk_result('0, 1'b0, '0, '0, fct_pkg::ST_RANGE));
        add_row(fct_pkg::KIND_WRITE, 28'd1, fct_pkg::ENTRY_MASK, 1'b1,
                mk_result('0, 1'b0, '0, '0, fct_pkg::ST_RANGE));
        add_row(fct_pkg::KIND_READ, 28'd4096, '0, 1'b1,
                mk_result('0, 1'b0, '0, '0, fct_pkg::ST_RANGE));
        add_row(fct_pkg::KIND_FREE, fct_pkg::ENTRY_MASK, '0, 1'b1,
                mk_result('0, 1'b0, '0, '0, fct_pkg::ST_RANGE));
        // A predecessor outside the table is refused before the count is looked at.
        add_row(fct_pkg::KIND_ALLOC, fct_pkg::ENTRY_MASK, '0, 1'b1,
                mk_result('0, 1'b0, '0, '0, fct_pkg::ST_RANGE));
        add_row(fct_pkg::KIND_ALLOC, 28'd0, '0, 1'b1,
                mk_result('0, 1'b0, '0, '0, fct_pkg::ST_FULL));
        add_row(fct_pkg::KIND_SET, 28'd0, fct_pkg::ENTRY_MASK, 1'b1,
                mk_result('0, 1'b0, '0, fct_pkg::ENTRY_MASK, fct_pkg::ST_OK));
        add_row(fct_pkg::KIND_WRITE, 28'd4095, fct_pkg::EOC_MARK, 1'b1,
                mk_result('0, 1'b0, 32'd4093, fct_pkg::ENTRY_MASK, fct_pkg::ST_OK));
        add_row(fct_pkg::KIND_READ, 28'd4095, '0, 1'b1,
                mk_result(fct_pkg::EOC_MARK, 1'b1, 32'd4093, fct_pkg::ENTRY_MASK,
                          fct_pkg::ST_OK));
        add_row(fct_pkg::KIND_ALLOC, 28'd0, '0, 1'b1,
                mk_result(28'd2, 1'b0, '0, fct_pkg::ENTRY_MASK - 1'b1, fct_pkg::ST_OK));
        // Build a two-cluster chain, then free it with the count at its ceiling.
        add_row(fct_pkg::KIND_ALLOC, 28'd2, '0, 1'b0, '0);
        add_row(fct_pkg::KIND_READ, 28'd2, '0, 1'b0, '0);
        add_row(fct_pkg::KIND_SET, 28'd0, fct_pkg::ENTRY_MASK, 1'b0, '0);
        add_row(fct_pkg::KIND_FREE, 28'd2, '0, 1'b0, '0);
        // Undefined operation codes leave everything alone.
        add_row(3'd5, fct_pkg::ENTRY_MASK, fct_pkg::ENTRY_MASK, 1'b0, '0);
        add_row(3'd6, 28'h0AAA_AAAA, 28'h0555_5555, 1'b0, '0);
        add_row(3'd7, 28'h0555_5555, 28'h0AAA_AAAA, 1'b0, '0);
        // Chains with a reserved link, a link just below end of chain, and a loop.
        add_row(fct_pkg::KIND_WRITE, 28'd5, 28'd1, 1'b0, '0);
        add_row(fct_pkg::KIND_FREE, 28'd5, '0, 1'b0, '0);
        add_row(fct_pkg::KIND_WRITE, 28'd6, fct_pkg::EOC_MIN - 1'b1, 1'b0, '0);
        add_row(fct_pkg::KIND_FREE, 28'd6, '0, 1'b0, '0);
        add_row(fct_pkg::KIND_WRITE, 28'd7, 28'd7, 1'b0, '0);
        add_row(fct_pkg::KIND_FREE, 28'd7, '0, 1'b0, '0);
        // Cluster two is the first free one again, so it becomes its own predecessor.
        add_row(fct_pkg::KIND_ALLOC, 28'd2, '0, 1'b0, '0);
        add_row(fct_pkg::KIND_READ, 28'd2, '0, 1'b0, '0);
        add_row(fct_pkg::KIND_SET, 28'd0, '0, 1'b0, '0);

        // Single reset at the start; the engine then clears its RAM on its own
        // while the first request beat waits for s_tready.
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;

        foreach (directed_rows[r])
            send_beat(directed_rows[r].kind, directed_rows[r].cluster, directed_rows[r].value,
                      directed_rows[r].typed, directed_rows[r].want);
        wait_drained();

        // Random phases. Each rotates the idle pattern and rewrites the registers.
        // The first uses the smallest table, where no cluster is valid, with the
        // largest sector size and an offset that wraps. Two use the full table;
        // the rest use small tables so that scans and chain walks stay short and
        // the table fills up and empties again often.
        for (phase = 0; phase < 13; phase++) begin
            case (phase % 4)
                0: begin
                    send_idle_pct  = 0;
                    recv_stall_pct = 0;
                end
                1: begin
                    send_idle_pct  = 84;
                    recv_stall_pct = 0;
                end
                2: begin
                    send_idle_pct  = 0;
                    recv_stall_pct = 84;
                end
                default: begin
                    send_idle_pct  = 25;
                    recv_stall_pct = 25;
                end
            endcase
            big = (phase == 1) || (phase == 7);
            if (phase == 0)
                set_config(8'd128, 32'hFFFF_FFFF, 13'd2);
            else if (phase == 1)
                set_config(8'd1, 32'd0, 13'd4096);
            else if (big)
                set_config(8'($urandom_range(1, 128)), $urandom, 13'd4096);
            else
                set_config(8'($urandom_range(1, 128)), $urandom, 13'($urandom_range(3, 48)));
            item_count = (phase == 0) ? 40 : (big ? 30 : 65);
            lim        = usable_limit();

            for (i = 0; i < item_count; i++) begin
                // Mostly valid clusters, with some zero and some anywhere in 28 bits.
                cluster = (lim > 2) ? 28'($urandom_range(2, lim - 1)) : 28'd0;
                sel     = $urandom_range(99);
                if (sel < 5)
                    cluster = '0;
                else if (sel < 12)
                    cluster = 28'($urandom);
                value = 28'($urandom);
                pick  = $urandom_range(99);
                if (pick < 18) begin
                    kind = fct_pkg::KIND_READ;
                end else if (pick < 38) begin
                    // Links are mostly end-of-chain marks or valid clusters, so that
                    // frees find real chains and sometimes loops.
                    kind = fct_pkg::KIND_WRITE;
                    sel  = $urandom_range(99);
                    if (sel < 35)
                        value = fct_pkg::EOC_MIN | 28'($urandom_range(7));
                    else if (sel < 70)
                        value = (lim > 2) ? 28'($urandom_range(2, lim - 1)) : 28'd0;
                    else if (sel < 80)
                        value = '0;
                end else if (pick < 63) begin
                    kind = fct_pkg::KIND_ALLOC;
                    if ($urandom_range(1) == 0)
                        cluster = '0;
                end else if (pick < 80) begin
                    kind = fct_pkg::KIND_FREE;
                end else if (pick < 88) begin
                    // Keep the count mostly small and nonzero; sometimes near the top.
                    kind = fct_pkg::KIND_SET;
                    sel  = $urandom_range(99);
                    if (sel < 70)
                        value = 28'($urandom_range(1, 64));
                    else if (sel < 85)
                        value = fct_pkg::ENTRY_MASK - 28'($urandom_range(3));
                end else if (pick < 94) begin
                    kind = 3'($urandom_range(5, 7));
                end else begin
                    kind = 3'($urandom);
                end
                send_beat(kind, cluster, value, 1'b0, '0);
            end
            wait_drained();
        end

        // Let the engine settle, then report.
        repeat (20) @(posedge aclk);
        if (mismatch_count == 0 && pending_results.size() == 0)
            $display("tb_fat32_cluster_table_engine: done, clean");
        else
            $display("tb_fat32_cluster_table_engine: done, errors");
        $finish;
    end

    // Watchdog: far beyond the slowest legal run, including the clearing pass.
    initial begin
        #(100_000_000);
        $display("tb_fat32_cluster_table_engine: done, errors");
        $finish;
    end

endmodule

@@ fat32_cluster_table_engine.f @@
sv/fct_pkg.sv
sv/fct_ram.sv
sv/fct_sector.sv
sv/fat32_cluster_table_engine.sv
test/tb_fat32_cluster_table_engine.sv
